### design/per_id_cpu_usage_sampler_defines.svh
// Assertion macros for the per-id cpu usage sampler.
`ifndef PER_ID_CPU_USAGE_SAMPLER_DEFINES_SVH
`define PER_ID_CPU_USAGE_SAMPLER_DEFINES_SVH
// Implication checked every clock, disabled during reset.
`define PICU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define PICU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### design/picu_pkg.sv
// Package: constants and shared types of the cpu usage sampler.
package picu_pkg;
  localparam int SLOTS     = 16;
  localparam int TICK_BITS = 48;
  localparam int ID_BITS   = 16;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int POS_BITS  = $clog2(SLOTS + 1);
  localparam int USE_BITS  = 10;
  localparam int SUM_BITS  = 14;
  localparam int PROD_BITS = TICK_BITS + 10;
  localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);
  localparam logic [USE_BITS-1:0] PERMILLE_FULL = 10'd1000;
  localparam logic [SUM_BITS-1:0] SUM_MAX = 14'd16383;

  typedef struct packed {
    logic                 first_of_sample;
    logic [TICK_BITS-1:0] now_ticks;
    logic                 has_record;
    logic [15:0]          proc_id;
    logic [TICK_BITS-1:0] user_ticks;
    logic [TICK_BITS-1:0] kernel_ticks;
    logic                 last_of_sample;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          slot_index;
    logic [15:0]         out_proc_id;
    logic [USE_BITS-1:0] usage_permille;
    logic [SUM_BITS-1:0] total_permille;
    logic                had_baseline;
    logic                dropped;
    logic                record_valid;
    logic                end_of_sample;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input item
    logic srch_step; // compare one slot
    logic div_start; // start the divide
    logic div_step;  // one quotient bit
    logic commit;    // write slot, update totals, load output
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic srch_done;
    logic need_div;
    logic div_done;
  } sts_t;
endpackage

### design/picu_if.sv
// Valid/ready channel interface carrying one transaction payload.
interface picu_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/per_id_cpu_usage_sampler.sv
// Top level of the per-id cpu usage sampler.
// One record per transaction; one result per transaction. An item passes from
// acceptance in idle to a serial search over the 16 baseline slots, one slot
// a cycle, stopping on the first hit (skipped for an item with no record or a
// dropped one), then on a hit with nonzero elapsed time a restoring divide of
// delta*1000 by elapsed time, one quotient bit per cycle, then commit and then
// output, where the result waits for any output stall. One item is in flight
// at a time; input is taken again once the result transaction completes.
`include "per_id_cpu_usage_sampler_defines.svh"
module per_id_cpu_usage_sampler import picu_pkg::*; (
  input logic clk,
  input logic rst_n,
  picu_if.sink   in_ch,
  picu_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;

  picu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  picu_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_ch.data), .cmd(cmd), .sts(sts), .out_data(out_ch.data)
  );

  // Never accept while a result is pending
  `PICU_ASSERT_IMP(a_no_overlap, clk, rst_n, out_ch.valid, !in_ch.ready)
  // Result stays until taken
  `PICU_ASSERT_NXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
  // Usage never exceeds full scale
  `PICU_ASSERT_IMP(a_usage_max, clk, rst_n, out_ch.valid, out_ch.data.usage_permille <= PERMILLE_FULL)
endmodule

### design/picu_ctrl.sv
// Controller state machine of the cpu usage sampler.
module picu_ctrl import picu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts.srch_done) begin
          if (sts.need_div) begin
            cmd.div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_COMMIT;
          end
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_COMMIT;
        else cmd.div_step = 1'b1;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

### design/picu_dp.sv
// Datapath: slot table, serial search, restoring divider, totals.
module picu_dp import picu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t out_data
);
  logic [SLOTS-1:0]     slot_valid_r;
  logic [ID_BITS-1:0]   slot_id_r [SLOTS];
  logic [TICK_BITS-1:0] slot_ticks_r [SLOTS];
  logic [TICK_BITS-1:0] prev_time_r;
  logic [POS_BITS-1:0]  pos_r;
  logic [SUM_BITS-1:0]  sum_r;

  in_item_t             item_r;
  logic [TICK_BITS-1:0] total_r, elapsed_r, prev_r;
  logic [POS_BITS-1:0]  jidx_r;
  logic                 found_r;
  logic [PROD_BITS-1:0] dvd_r;
  logic [TICK_BITS:0]   rem_r;
  logic [DIV_CNT_BITS-1:0] dcnt_r;
  logic [POS_BITS-1:0]  cpos;
  logic [SUM_BITS-1:0]  csum;
  logic                 active;
  logic [TICK_BITS-1:0] delta;
  logic [TICK_BITS:0]   trial;
  logic                 over;
  logic [USE_BITS-1:0]  usage;
  logic [SUM_BITS:0]    sum_add;
  logic [ID_BITS-1:0]   id_in;
  logic [SLOT_BITS-1:0] jsel, psel;

  // Position and total as seen by this record (first mark restarts them)
  assign cpos   = item_r.first_of_sample ? '0 : pos_r;
  assign csum   = item_r.first_of_sample ? '0 : sum_r;
  assign active = item_r.has_record && (cpos < POS_BITS'(SLOTS));
  assign id_in  = item_r.proc_id[ID_BITS-1:0];
  assign jsel   = jidx_r[SLOT_BITS-1:0];
  assign psel   = cpos[SLOT_BITS-1:0];
  assign delta  = total_r - prev_r;
  assign trial  = {rem_r[TICK_BITS-1:0], dvd_r[PROD_BITS-1]} - {1'b0, elapsed_r};

  assign sts.srch_done = found_r || (jidx_r == POS_BITS'(SLOTS)) || !active;
  assign sts.need_div  = active && found_r && (elapsed_r != '0);
  assign sts.div_done  = (dcnt_r == '0);

  // Quotient above 1000 saturates to full scale; any bit above the low ten means over 1000
  assign over  = (dvd_r[PROD_BITS-1:USE_BITS] != '0) || (dvd_r[USE_BITS-1:0] > 10'(PERMILLE_FULL));
  assign usage = !sts.need_div ? '0 : (over ? PERMILLE_FULL : dvd_r[USE_BITS-1:0]);
  assign sum_add = {1'b0, csum} + {{(SUM_BITS-USE_BITS+1){1'b0}}, usage};

  // Item capture, search and divide
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r    <= in_data;
      total_r   <= in_data.user_ticks + in_data.kernel_ticks;
      elapsed_r <= in_data.now_ticks - prev_time_r;
      jidx_r    <= '0;
      found_r   <= 1'b0;
    end
    if (cmd.srch_step) begin
      if (slot_valid_r[jsel] && slot_id_r[jsel] == id_in) begin
        found_r <= 1'b1;
        prev_r  <= slot_ticks_r[jsel];
      end else begin
        jidx_r <= jidx_r + 1'b1;
      end
    end
    if (cmd.div_start) begin
      // delta * 1000 = delta * 1024 - delta * 16 - delta * 8
      dvd_r  <= {delta, 10'b0} - {6'b0, delta, 4'b0} - {7'b0, delta, 3'b0};
      rem_r  <= '0;
      dcnt_r <= DIV_CNT_BITS'(PROD_BITS);
    end
    if (cmd.div_step) begin
      if (!trial[TICK_BITS]) begin
        rem_r <= trial;
        dvd_r <= {dvd_r[PROD_BITS-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[TICK_BITS-1:0], dvd_r[PROD_BITS-1]};
        dvd_r <= {dvd_r[PROD_BITS-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.commit) begin
      if (active) begin
        slot_id_r[psel]    <= id_in;
        slot_ticks_r[psel] <= total_r;
      end
      out_data.slot_index     <= active ? 4'(cpos) : 4'd0;
      out_data.out_proc_id    <= item_r.has_record ? item_r.proc_id : 16'd0;
      out_data.usage_permille <= usage;
      out_data.total_permille <= !active ? csum :
                                 (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_BITS-1:0];
      out_data.had_baseline   <= active && found_r;
      out_data.dropped        <= item_r.has_record && !active;
      out_data.record_valid   <= item_r.has_record;
      out_data.end_of_sample  <= item_r.last_of_sample;
    end
  end

  // Control state of the table and sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      prev_time_r  <= '0;
      pos_r        <= '0;
      sum_r        <= '0;
    end else if (cmd.commit) begin
      pos_r <= active ? cpos + 1'b1 : cpos;
      sum_r <= !active ? csum :
               (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_BITS-1:0];
      if (active) slot_valid_r[psel] <= 1'b1;
      if (item_r.last_of_sample) prev_time_r <= item_r.now_ticks;
    end
  end
endmodule
